>>> sv/rde_pkg.sv
package rde_pkg;

   localparam int MAX_SYMBOLS = 16;
   localparam int BASE_W      = $clog2(MAX_SYMBOLS + 1);
   localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
   localparam int VALUE_W     = 32;
   localparam int MAX_DIGITS  = VALUE_W;
   localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int SYM_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'd43;
   localparam logic [SYM_W-1:0] SIGN_MINUS = 8'd45;
   localparam logic [BASE_W-1:0] MIN_RADIX = BASE_W'(2);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [4:0]            RADIX_RESET        = 5'd10;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h4645444342413938;

   // floor(2^32 / b); the estimate it gives is the quotient or one below it
   localparam logic [VALUE_W-1:0] RECIP_TABLE [MAX_SYMBOLS+1] = '{
      32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
      32'h4000_0000, 32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924,
      32'h2000_0000, 32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174,
      32'h1555_5555, 32'h13B1_3B13, 32'h1249_2492, 32'h1111_1111,
      32'h1000_0000
   };

   typedef struct packed {
      logic load;
      logic mul;
      logic fix;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic alpha_ok;
      logic quot_zero;
      logic neg;
      logic last_digit;
      logic out_free;
   } status_type;

endpackage

>>> sv/rde_ctrl.sv
module rde_ctrl
   import rde_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = !reset && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // a bad alphabet drops the transaction with no output
            if (status.alpha_ok) begin
               cmd.mul  = 1'b1;
               state_in = ST_FIX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            if (!status.quot_zero) begin
               state_in = ST_MUL;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/rde_dp.sv
module rde_dp
   import rde_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SYM_W-1:0]       rsp_symbol,
   output logic                   rsp_last
);

   // configuration registers
   logic [4:0]            radix_ff;
   logic [CSR_DATA_W-1:0] symbols_low_ff;
   logic [CSR_DATA_W-1:0] symbols_high_ff;

   logic [SYM_W-1:0]  sym_lut [MAX_SYMBOLS];
   logic [BASE_W-1:0] base_sat;
   logic              alpha_ok_in;
   logic              alpha_ok_ff;

   // working registers
   logic [VALUE_W-1:0] mag_ff;
   logic               neg_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [VALUE_W-1:0] recip_ff;
   logic [VALUE_W-1:0] qest_ff;
   logic [VALUE_W-1:0] qest_in;
   logic [DIGIT_W-1:0] digits_ff [MAX_DIGITS];
   logic [COUNT_W-1:0] count_ff;

   logic [2*VALUE_W-1:0]      prod_full;
   logic [VALUE_W+BASE_W-1:0] qb_full;
   logic [VALUE_W-1:0]        rem_wide;
   logic [BASE_W:0]           rem_small;
   logic                      rem_big;
   logic [BASE_W:0]           digit_wide;
   logic [VALUE_W-1:0]        quot;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SYM_W-1:0]   rsp_symbol_ff;
   logic               rsp_last_ff;
   logic [VALUE_W-1:0] raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= RADIX_RESET;
         symbols_low_ff  <= SYMBOLS_LOW_RESET;
         symbols_high_ff <= SYMBOLS_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIX:        radix_ff        <= csr_data[4:0];
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         if (k < 8) begin
            sym_lut[k] = symbols_low_ff[8*k +: 8];
         end else begin
            sym_lut[k] = symbols_high_ff[8*(k-8) +: 8];
         end
      end
   end

   assign base_sat = (radix_ff > 5'(MAX_SYMBOLS)) ? BASE_W'(MAX_SYMBOLS)
                                                  : BASE_W'(radix_ff);

   // radix check, '+'/'-' check and pairwise compare of the symbols in use, registered
   always_comb begin
      alpha_ok_in = (base_sat >= MIN_RADIX);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (BASE_W'(i) < base_sat) begin
            if (sym_lut[i] == SIGN_PLUS || sym_lut[i] == SIGN_MINUS) begin
               alpha_ok_in = 1'b0;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
               if (BASE_W'(j) < base_sat && sym_lut[i] == sym_lut[j]) begin
                  alpha_ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      alpha_ok_ff <= alpha_ok_in;
   end

   // quotient estimate, then remainder and one correction
   assign prod_full = {{VALUE_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, recip_ff};
   assign qest_in   = prod_full[2*VALUE_W-1:VALUE_W];
   assign qb_full   = {{BASE_W{1'b0}}, qest_ff} * {{VALUE_W{1'b0}}, base_ff};
   assign rem_wide  = mag_ff - qb_full[VALUE_W-1:0];
   assign rem_small = rem_wide[BASE_W:0];
   assign rem_big   = (rem_small >= {1'b0, base_ff});
   assign digit_wide = rem_big ? (rem_small - {1'b0, base_ff}) : rem_small;
   assign quot      = qest_ff + VALUE_W'(rem_big);

   assign raw = req_value;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff   <= raw[VALUE_W-1];
         mag_ff   <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
         base_ff  <= base_sat;
         recip_ff <= RECIP_TABLE[base_sat];
      end else if (cmd.fix) begin
         mag_ff <= quot;
      end
      if (cmd.mul) begin
         qest_ff <= qest_in;
      end
   end

   // digit stack, least significant pushed first, popped from the top
   always_ff @(posedge clock) begin
      if (cmd.fix) begin
         digits_ff[0] <= digit_wide[DIGIT_W-1:0];
         for (int k = 1; k < MAX_DIGITS; k++) begin
            digits_ff[k] <= digits_ff[k-1];
         end
      end else if (cmd.emit_digit) begin
         for (int k = 0; k < MAX_DIGITS - 1; k++) begin
            digits_ff[k] <= digits_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.fix) begin
         count_ff <= count_ff + COUNT_W'(1);
      end else if (cmd.emit_digit) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   // output register
   assign rsp_valid_in = (cmd.emit_sign || cmd.emit_digit) ? 1'b1
                       : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit_sign) begin
         rsp_symbol_ff <= SIGN_MINUS;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_symbol_ff <= sym_lut[digits_ff[0]];
         rsp_last_ff   <= (count_ff == COUNT_W'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   assign status.alpha_ok   = alpha_ok_ff;
   assign status.quot_zero  = (quot == '0);
   assign status.neg        = neg_ff;
   assign status.last_digit = (count_ff == COUNT_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_DIGITS))
      else $error("digit count beyond word size");

   a_digit_below_base: assert property (@(posedge clock) disable iff (reset)
      cmd.fix |-> digit_wide < {1'b0, base_ff})
      else $error("digit not reduced below base");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> count_ff != '0)
      else $error("digit emitted from empty stack");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");
`endif

endmodule

>>> sv/radix_digit_emitter_top.sv
// radix_digit_emitter_top: converts one signed 32-bit value per transaction
// into a run of symbol bytes, most significant digit first, with rsp_last on
// the final byte. radix (saturated at 16) sets the base and the two symbol
// registers hold the alphabet, byte k being digit k. a negative value gives
// '-' first, then the digits of its magnitude (the most negative value is
// exact); zero gives symbol 0 alone. if the base is below two, or a symbol in
// use is '+' or '-', or two symbols in use repeat, the transaction is taken
// and produces no output. one value is handled at a time: req_ready is high
// only while idle. after acceptance each digit passes through the shared
// divider in two steps (a reciprocal multiply, then a remainder fix-up),
// after which the bytes leave from the output register at one per cycle while
// rsp_ready is high. configuration writes are accepted in any cycle outside
// reset and must only happen while idle.
module radix_digit_emitter_top
   import rde_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input transaction
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   // output transaction, one per symbol byte
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SYM_W-1:0]          rsp_symbol,
   output logic                      rsp_last,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cmd_type    cmd;
   status_type status;

   // registers live in the datapath and take a write in any cycle out of reset
   assign csr_ready = !reset;

   // sequencer: accept, divide loop, sign, digit pops
   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // divider, digit stack, alphabet check and output register
   rde_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_value  (req_value),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule
